// ===== rtl/ahdlc_pkg.sv =====
// Package for the async HDLC deframer: register indexes, record codes,
// configuration and record structs, reset values and the byte-wise CRC-16.
// No dependencies.
package ahdlc_pkg;

  localparam logic [15:0] CrcPoly = 16'h8408;

  localparam logic [7:0]  FlagReset    = 8'h7E;
  localparam logic [7:0]  EscapeReset  = 8'h7D;
  localparam logic [7:0]  MaskReset    = 8'h20;
  localparam logic [15:0] SeedReset    = 16'hFFFF;
  localparam logic [15:0] ResidueReset = 16'h0F47;
  localparam logic        HuntReset    = 1'b0;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegFlag    = 3'd0,
    RegEscape  = 3'd1,
    RegMask    = 3'd2,
    RegSeed    = 3'd3,
    RegResidue = 3'd4,
    RegHunt    = 3'd5
  } ahdlc_reg_e;

  typedef enum logic [1:0] {
    StGood     = 2'd0,
    StCrcErr   = 2'd1,
    StShort    = 2'd2,
    StOverflow = 2'd3
  } ahdlc_status_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindEnd     = 1'b1
  } ahdlc_kind_e;

  typedef struct packed {
    logic [7:0]  flag_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  escape_mask;
    logic [15:0] crc_seed;
    logic [15:0] crc_good_residue;
    logic        hunt_mode;
  } ahdlc_cfg_t;

  typedef struct packed {
    ahdlc_kind_e   record_kind;
    logic [7:0]    payload_byte;
    logic [15:0]   frame_length;
    ahdlc_status_e frame_status;
  } ahdlc_rec_t;

  // Reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/ahdlc_intf.sv =====
// Channel interfaces of the async HDLC deframer: received bytes, output
// records and configuration writes. Depends on ahdlc_pkg for widths.
interface ahdlc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ahdlc_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  payload_byte;
  logic [15:0] frame_length;
  logic [1:0]  frame_status;
  modport source (output valid, output record_kind, output payload_byte,
                  output frame_length, output frame_status, input ready);
  modport sink   (input valid, input record_kind, input payload_byte,
                  input frame_length, input frame_status, output ready);
endinterface

interface ahdlc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ahdlc_pkg::CfgIdxW-1:0] index;
  logic [ahdlc_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ahdlc_cfg_regs.sv =====
// Configuration register file of the async HDLC deframer.
// Depends on ahdlc_pkg and ahdlc_cfg_if.
module ahdlc_cfg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ahdlc_cfg_if.sink             cfg_i,
  output ahdlc_pkg::ahdlc_cfg_t cfg_o
);
  import ahdlc_pkg::*;

  ahdlc_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte        <= FlagReset;
      cfg_q.escape_byte      <= EscapeReset;
      cfg_q.escape_mask      <= MaskReset;
      cfg_q.crc_seed         <= SeedReset;
      cfg_q.crc_good_residue <= ResidueReset;
      cfg_q.hunt_mode        <= HuntReset;
    end else if (cfg_i.valid) begin
      unique case (ahdlc_reg_e'(cfg_i.index))
        RegFlag:    cfg_q.flag_byte        <= cfg_i.data[7:0];
        RegEscape:  cfg_q.escape_byte      <= cfg_i.data[7:0];
        RegMask:    cfg_q.escape_mask      <= cfg_i.data[7:0];
        RegSeed:    cfg_q.crc_seed         <= cfg_i.data;
        RegResidue: cfg_q.crc_good_residue <= cfg_i.data;
        RegHunt:    cfg_q.hunt_mode        <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ahdlc_deframe.sv =====
// Frame state and per-byte logic: unstuffing, CRC, two-byte hold-back,
// length count and end-of-frame status. Depends on ahdlc_pkg.
module ahdlc_deframe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ahdlc_pkg::ahdlc_cfg_t cfg_i,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  res_valid_o,
  output ahdlc_pkg::ahdlc_rec_t res_o
);
  import ahdlc_pkg::*;

  logic        esc_q, esc_d;
  logic        hdr_q, hdr_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held_q [2];
  logic [7:0]  held_d [2];
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [15:0] cnt_q, cnt_d;
  logic        ovf_q, ovf_d;

  logic        do_take;
  logic        do_end;
  logic [7:0]  data;

  always_comb begin
    hdr_d   = hdr_q;
    esc_d   = esc_q;
    do_take = 1'b0;
    do_end  = 1'b0;
    data    = byte_i;
    if (step_i) begin
      priority if (cfg_i.hunt_mode && !hdr_q) begin
        if (byte_i == cfg_i.flag_byte) hdr_d = 1'b1;
      end else if (esc_q) begin
        esc_d   = 1'b0;
        data    = byte_i ^ cfg_i.escape_mask;
        do_take = 1'b1;
      end else if (byte_i == cfg_i.escape_byte) begin
        esc_d = 1'b1;
      end else if (byte_i == cfg_i.flag_byte) begin
        do_end = 1'b1;
      end else begin
        do_take = 1'b1;
      end
    end
  end

  always_comb begin
    crc_d       = crc_q;
    held_d      = held_q;
    held_cnt_d  = held_cnt_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (do_take) begin
      crc_d = crc_add_byte(crc_q, data);
      if (!held_cnt_q[1]) begin
        held_d[held_cnt_q[0]] = data;
        held_cnt_d            = held_cnt_q + 2'd1;
      end else begin
        held_d[0]          = held_q[1];
        held_d[1]          = data;
        res_valid_o        = 1'b1;
        res_o.record_kind  = KindPayload;
        res_o.payload_byte = held_q[0];
        if (&cnt_q) begin
          ovf_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 16'd1;
        end
      end
    end else if (do_end) begin
      res_valid_o        = 1'b1;
      res_o.record_kind  = KindEnd;
      res_o.frame_length = cnt_q;
      priority if (!held_cnt_q[1]) begin
        res_o.frame_status = StShort;
        res_o.frame_length = '0;
      end else if (ovf_q) begin
        res_o.frame_status = StOverflow;
      end else if (~crc_q == cfg_i.crc_good_residue) begin
        res_o.frame_status = StGood;
      end else begin
        res_o.frame_status = StCrcErr;
      end
      crc_d      = cfg_i.crc_seed;
      held_cnt_d = '0;
      cnt_d      = '0;
      ovf_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      hdr_q      <= 1'b0;
      crc_q      <= SeedReset;
      held_cnt_q <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
    end else if (do_end) begin
      esc_q      <= 1'b0;
      hdr_q      <= 1'b0;
      crc_q      <= crc_d;
      held_cnt_q <= held_cnt_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
    end else begin
      esc_q      <= esc_d;
      hdr_q      <= hdr_d;
      crc_q      <= crc_d;
      held_cnt_q <= held_cnt_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// ===== rtl/async_hdlc_deframer_crc16_top.sv =====
// Async HDLC deframer with CRC-16 check, top level.
// Depends on ahdlc_pkg, the ahdlc interfaces, ahdlc_cfg_regs, ahdlc_deframe.
//
// Takes one received line byte per transfer on rx_i and gives payload bytes
// and one end record per frame on rec_o. A byte passes an input register,
// the frame logic (unstuffing, byte-wise CRC-16, two-byte hold-back) and
// a result register, and one byte is taken every cycle while the result
// register is free or being drained. Configuration writes on cfg_i are
// always ready and are to be made only while no frame byte is in flight.
module async_hdlc_deframer_crc16_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ahdlc_rx_if.sink   rx_i,
  ahdlc_cfg_if.sink  cfg_i,
  ahdlc_rec_if.source rec_o
);
  import ahdlc_pkg::*;

  ahdlc_cfg_t cfg;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  ahdlc_rec_t out_q;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  ahdlc_rec_t res;

  assign out_free   = !out_vld_q || rec_o.ready;
  assign advance    = in_vld_q && out_free;
  assign rx_i.ready = !in_vld_q || out_free;

  ahdlc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ahdlc_deframe u_deframe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rx_i.ready) in_vld_q <= rx_i.valid;
      if (advance) begin
        out_vld_q <= res_valid;
      end else if (rec_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) in_byte_q <= rx_i.rx_byte;
    if (advance && res_valid) out_q <= res;
  end

  assign rec_o.valid        = out_vld_q;
  assign rec_o.record_kind  = out_q.record_kind;
  assign rec_o.payload_byte = out_q.payload_byte;
  assign rec_o.frame_length = out_q.frame_length;
  assign rec_o.frame_status = out_q.frame_status;

endmodule

// ===== tb/tb_async_hdlc_deframer_crc16_top.sv =====
// Testbench for async_hdlc_deframer_crc16_top: random line bytes and stuffed
// frames against a cycle-free deframer predictor, records checked in order.
// Depends on ahdlc_pkg, the ahdlc channel interfaces and the RTL top level.
`timescale 1ns / 100ps

module tb_async_hdlc_deframer_crc16_top;
  import ahdlc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  ahdlc_rx_if  rx_if ();
  ahdlc_cfg_if cfg_if ();
  ahdlc_rec_if rec_if ();

  logic                rx_valid  = 1'b0;
  logic [7:0]          rx_data   = 8'h00;
  logic                rec_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  assign rx_if.valid    = rx_valid;
  assign rx_if.rx_byte  = rx_data;
  assign rec_if.ready   = rec_ready;
  assign cfg_if.valid   = cfg_valid;
  assign cfg_if.index   = cfg_index;
  assign cfg_if.data    = cfg_data;

  async_hdlc_deframer_crc16_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .rec_o  (rec_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  // Shared state
  ahdlc_cfg_t   cfg_now;
  logic [7:0]   rx_pending[$];
  ahdlc_rec_t   due_records[$];
  logic [7:0]   frame_body[$];
  logic [15:0]  next_frame_crc = SeedReset;
  int           pushed_total = 0;
  int           err_count = 0;
  logic         rx_took = 1'b0;
  logic         idle_on = 1'b1;
  logic         hold_off = 1'b0;
  int           rx_gap = 0;
  int           rx_calm = 0;
  int           rdy_gap = 0;
  int           rdy_calm = 0;

  // Deframer prediction state
  logic         df_esc;
  logic         df_hdr;
  logic [15:0]  df_crc;
  logic [7:0]   df_held[2];
  logic [1:0]   df_held_cnt;
  logic [15:0]  df_len;
  logic         df_ovf;

  function automatic logic [15:0] fcs16_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 40) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
    err_count++;
  endtask

  task automatic clear_frame_state();
    df_esc      = 1'b0;
    df_hdr      = 1'b0;
    df_crc      = cfg_now.crc_seed;
    df_held_cnt = 2'd0;
    df_len      = 16'h0000;
    df_ovf      = 1'b0;
  endtask

  task automatic take_unstuffed(input logic [7:0] d);
    ahdlc_rec_t r;
    df_crc = fcs16_byte(df_crc, d);
    if (df_held_cnt < 2'd2) begin
      df_held[df_held_cnt[0]] = d;
      df_held_cnt++;
    end else begin
      r = '0;
      r.record_kind  = KindPayload;
      r.payload_byte = df_held[0];
      r.frame_length = 16'h0000;
      r.frame_status = StGood;
      df_held[0] = df_held[1];
      df_held[1] = d;
      if (df_len == 16'hFFFF) begin
        df_ovf = 1'b1;
      end else begin
        df_len++;
      end
      due_records.push_back(r);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    ahdlc_rec_t  r;
    logic [15:0] crc_inv;
    if (cfg_now.hunt_mode && !df_hdr) begin
      if (b == cfg_now.flag_byte) begin
        df_hdr = 1'b1;
      end
    end else if (df_esc) begin
      df_esc = 1'b0;
      take_unstuffed(b ^ cfg_now.escape_mask);
    end else if (b == cfg_now.escape_byte) begin
      df_esc = 1'b1;
    end else if (b == cfg_now.flag_byte) begin
      r = '0;
      r.record_kind  = KindEnd;
      r.payload_byte = 8'h00;
      r.frame_length = df_len;
      crc_inv = ~df_crc;
      if (df_held_cnt < 2'd2) begin
        r.frame_status = StShort;
        r.frame_length = 16'h0000;
      end else if (df_ovf) begin
        r.frame_status = StOverflow;
      end else if (crc_inv == cfg_now.crc_good_residue) begin
        r.frame_status = StGood;
      end else begin
        r.frame_status = StCrcErr;
      end
      clear_frame_state();
      due_records.push_back(r);
    end else begin
      take_unstuffed(b);
    end
  endtask

  // Predictor: follows every accepted byte and register write
  always @(posedge clk_i) begin
    if (!rst_n) begin
      cfg_now.flag_byte        = FlagReset;
      cfg_now.escape_byte      = EscapeReset;
      cfg_now.escape_mask      = MaskReset;
      cfg_now.crc_seed         = SeedReset;
      cfg_now.crc_good_residue = ResidueReset;
      cfg_now.hunt_mode        = HuntReset;
      clear_frame_state();
      rx_took <= 1'b0;
    end else begin
      rx_took <= rx_valid && rx_if.ready;
      if (rx_valid && rx_if.ready) begin
        deframe_byte(rx_data);
      end
      if (cfg_valid && cfg_if.ready) begin
        case (ahdlc_reg_e'(cfg_index))
          RegFlag:    cfg_now.flag_byte        = cfg_data[7:0];
          RegEscape:  cfg_now.escape_byte      = cfg_data[7:0];
          RegMask:    cfg_now.escape_mask      = cfg_data[7:0];
          RegSeed:    cfg_now.crc_seed         = cfg_data;
          RegResidue: cfg_now.crc_good_residue = cfg_data;
          RegHunt:    cfg_now.hunt_mode        = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Record monitor
  always @(posedge clk_i) begin
    ahdlc_rec_t want;
    if (rst_n && rec_if.valid && rec_ready) begin
      if (due_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record kind %0d byte %02h len %0d st %0d",
                                  rec_if.record_kind, rec_if.payload_byte,
                                  rec_if.frame_length, rec_if.frame_status));
      end else begin
        want = due_records.pop_front();
        if (rec_if.record_kind !== want.record_kind) begin
          report_mismatch($sformatf("record_kind %0d, expected %0d",
                                    rec_if.record_kind, want.record_kind));
        end
        if (rec_if.payload_byte !== want.payload_byte) begin
          report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                    rec_if.payload_byte, want.payload_byte));
        end
        if (rec_if.frame_length !== want.frame_length) begin
          report_mismatch($sformatf("frame_length %0d, expected %0d",
                                    rec_if.frame_length, want.frame_length));
        end
        if (rec_if.frame_status !== want.frame_status) begin
          report_mismatch($sformatf("frame_status %0d, expected %0d",
                                    rec_if.frame_status, want.frame_status));
        end
      end
    end
  end

  // Mostly short gaps, a few long ones, and calm stretches with none
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Byte driver
  always @(negedge clk_i) begin
    if (rst_n && (!rx_valid || rx_took)) begin
      if (idle_on && rx_gap > 0) begin
        rx_valid <= 1'b0;
        rx_gap--;
      end else if (rx_pending.size() > 0) begin
        rx_valid <= 1'b1;
        rx_data  <= rx_pending.pop_front();
        if (idle_on) begin
          rx_gap = next_gap(rx_calm);
        end
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Record receiver back-pressure
  always @(negedge clk_i) begin
    if (hold_off) begin
      rec_ready <= 1'b0;
    end else if (!idle_on || rdy_gap == 0) begin
      rec_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) begin
        rdy_gap = next_gap(rdy_calm);
      end
    end else begin
      rec_ready <= 1'b0;
      rdy_gap--;
    end
  end

  // One long receiver hold-off while the sender keeps offering bytes
  initial begin : receiver_hold
    @(posedge rst_n);
    do @(posedge clk_i); while (rx_pending.size() < 120);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic write_reg(input ahdlc_reg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!(cfg_valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < 6) begin
      @(posedge clk_i);
      if (rx_pending.size() == 0 && !rx_valid && due_records.size() == 0) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
  endtask

  task automatic push_raw(input logic [7:0] b);
    rx_pending.push_back(b);
    pushed_total++;
  endtask

  task automatic push_stuffed(input logic [7:0] b, input bit extra);
    if (b == cfg_now.flag_byte || b == cfg_now.escape_byte || extra) begin
      push_raw(cfg_now.escape_byte);
      push_raw(b ^ cfg_now.escape_mask);
    end else begin
      push_raw(b);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return cfg_now.flag_byte;
      1:       return cfg_now.escape_byte;
      2:       return cfg_now.flag_byte ^ cfg_now.escape_mask;
      3:       return cfg_now.escape_byte ^ cfg_now.escape_mask;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic fill_random_body(input int n);
    frame_body.delete();
    repeat (n) frame_body.push_back(pick_byte());
  endtask

  // Stuffed frame from frame_body with FCS appended, bad FCS when asked
  task automatic push_frame(input bit good);
    logic [15:0] c;
    logic [15:0] fcs;
    if (cfg_now.hunt_mode) begin
      if ($urandom_range(0, 3) == 0) begin
        push_raw(pick_byte());
      end
      push_raw(cfg_now.flag_byte);
    end
    c = next_frame_crc;
    foreach (frame_body[i]) begin
      c = fcs16_byte(c, frame_body[i]);
      push_stuffed(frame_body[i], $urandom_range(0, 15) == 0);
    end
    fcs = ~c;
    if (!good) begin
      fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
    end
    push_stuffed(fcs[7:0], 1'b0);
    push_stuffed(fcs[15:8], 1'b0);
    push_raw(cfg_now.flag_byte);
    next_frame_crc = cfg_now.crc_seed;
  endtask

  task automatic push_random_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      if ($urandom_range(0, 99) < 85) begin
        fill_random_body($urandom_range(0, 12));
      end else begin
        fill_random_body($urandom_range(13, 48));
      end
      push_frame($urandom_range(0, 6) != 0);
    end else if (r < 86) begin
      repeat ($urandom_range(1, 6)) push_raw(pick_byte());
      next_frame_crc = cfg_now.crc_seed;
    end else if (r < 93) begin
      // escape swallows the first flag as data
      repeat ($urandom_range(0, 3)) push_stuffed(pick_byte(), 1'b0);
      push_raw(cfg_now.escape_byte);
      push_raw(cfg_now.flag_byte);
      push_raw(cfg_now.flag_byte);
      next_frame_crc = cfg_now.crc_seed;
    end else begin
      repeat ($urandom_range(0, 1)) push_stuffed(pick_byte(), 1'b0);
      push_raw(cfg_now.flag_byte);
      next_frame_crc = cfg_now.crc_seed;
    end
  endtask

  task automatic set_phase_cfg(input int p);
    logic [7:0]  f;
    logic [7:0]  e;
    logic [7:0]  m;
    logic [15:0] s;
    logic [15:0] res;
    logic        h;
    f = 8'($urandom_range(0, 255));
    e = 8'($urandom_range(0, 255));
    while (e == f) e = 8'($urandom_range(0, 255));
    m = 8'($urandom_range(0, 255));
    s = 16'($urandom_range(0, 65535));
    res = ResidueReset;
    if ($urandom_range(0, 3) == 0) begin
      res = 16'($urandom_range(0, 65535));
    end
    h = 1'($urandom_range(0, 1));
    case (p)
      0: begin
        f = 8'h00; e = 8'hFF; m = 8'h00; s = 16'h0000; h = 1'b1;
      end
      1: begin
        f = 8'hFF; e = 8'h00; m = 8'hFF; s = 16'hFFFF; res = 16'h0000; h = 1'b0;
      end
      2: e = f;
      3: res = 16'hFFFF;
      default: ;
    endcase
    write_reg(RegFlag,    {8'h00, f});
    write_reg(RegEscape,  {8'h00, e});
    write_reg(RegMask,    {8'h00, m});
    write_reg(RegSeed,    s);
    write_reg(RegResidue, res);
    write_reg(RegHunt,    {15'h0000, h});
  endtask

  initial begin : stimulus
    int phase;
    int rand_items;
    int start;
    int target;
    phase = 0;
    rand_items = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: empty and back-to-back flags, one-byte frame, stuffed good
    // frame, bad FCS, escape before flag and escape before escape
    push_raw(FlagReset);
    push_raw(FlagReset);
    push_raw(8'h55);
    push_raw(FlagReset);
    frame_body.delete();
    frame_body.push_back(8'h00);
    frame_body.push_back(8'hFF);
    frame_body.push_back(FlagReset);
    frame_body.push_back(EscapeReset);
    push_frame(1'b1);
    frame_body.delete();
    frame_body.push_back(8'hA5);
    frame_body.push_back(8'h5A);
    push_frame(1'b0);
    push_raw(EscapeReset);
    push_raw(FlagReset);
    push_raw(EscapeReset);
    push_raw(EscapeReset);
    push_raw(FlagReset);
    wait_idle();

    // Hunt: escape ignored before the opening flag
    write_reg(RegHunt, 16'h0001);
    @(posedge clk_i);
    push_raw(EscapeReset);
    frame_body.delete();
    frame_body.push_back(8'h00);
    push_frame(1'b1);
    push_raw(FlagReset);
    push_raw(FlagReset);
    wait_idle();

    while (rand_items < 1350) begin
      set_phase_cfg(phase);
      @(posedge clk_i);
      start = pushed_total;
      if (phase == 2) begin
        repeat (20) push_raw(pick_byte());
      end else begin
        target = $urandom_range(150, 300);
        while (pushed_total - start < target) push_random_unit();
        // leave a frame open across the next register writes
        if ($urandom_range(0, 2) == 0) begin
          repeat (3) push_raw(pick_byte());
        end
      end
      rand_items += pushed_total - start;
      wait_idle();
      phase++;
    end

    repeat (10) @(posedge clk_i);
    if (due_records.size() != 0) begin
      report_mismatch($sformatf("%0d expected records never arrived", due_records.size()));
    end
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
